// File: rtl/cvl_pkg.sv
package cvl_pkg;

	localparam int DEPTH      = 64;
	localparam int VALUE_BITS = 24;
	localparam int IDX_BITS   = $clog2(DEPTH);
	localparam int CNT_BITS   = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ACT_FIND   = 3'd0,
		ACT_APPEND = 3'd1,
		ACT_REMOVE = 3'd2,
		ACT_READ   = 3'd3,
		ACT_CLEAR  = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic cmp_en;
		logic append_en;
		logic shift_en;
	} cell_ctl_t;

endpackage

// File: rtl/cvl_cell.sv
module cvl_cell import cvl_pkg::*; (
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic                  valid,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [VALUE_BITS-1:0] next_entry,
	output logic [VALUE_BITS-1:0] entry,
	output logic                  match
);

	logic [VALUE_BITS-1:0] entry_q;
	logic                  match_q;

	always_ff @(posedge clk) begin
		if (ctl.append_en) begin
			entry_q <= value;
		end else if (ctl.shift_en) begin
			entry_q <= next_entry;
		end
		if (ctl.cmp_en) begin
			match_q <= valid && (entry_q == value);
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

// File: rtl/compacting_value_list_core.sv
// channel | direction | tdata fields (lowest bit up)
// s_axis  | in        | action[2:0] value_in[26:3] position_in[32:27], zeros to bit 39
// m_axis  | out       | status[1:0] position_out[7:2] value_out[31:8] count[38:32], zeros to 39
//
// On the input transfer every cell compares its entry and registers a hit. In the
// EXEC state the first hit is encoded, the result is registered and the cells append,
// shift down or hold.
// A held result stalls the EXEC state until the output transfer frees the register.
// Reset empties the list; entries are not cleared.
module compacting_value_list_core import cvl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // action, value_in, position_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // status, position_out, value_out, count
);

	typedef enum logic {IDLE, EXEC} state_t;

	state_t                state_q;
	logic [CNT_BITS-1:0]   held_q;
	logic [2:0]            act_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [IDX_BITS-1:0]   pos_q;

	logic [VALUE_BITS-1:0] entry [DEPTH];
	logic [DEPTH-1:0]      match;
	logic [DEPTH-1:0]      prefix;
	logic [DEPTH-1:0]      valid;
	logic [VALUE_BITS-1:0] bus_value;
	logic                  in_xfer;
	logic                  fire;
	logic                  hit;
	logic [IDX_BITS-1:0]   hit_pos;
	logic                  full;

	status_t               res_status;
	logic [IDX_BITS-1:0]   res_pos;
	logic [VALUE_BITS-1:0] res_value;
	logic [CNT_BITS-1:0]   res_held;
	logic                  do_append;
	logic                  do_remove;

	assign s_tready  = (state_q == IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign fire      = (state_q == EXEC) && (!m_tvalid || m_tready);
	assign bus_value = (state_q == IDLE) ? s_tdata[26:3] : value_q;
	assign full      = (held_q == CNT_BITS'(DEPTH));

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		cell_ctl_t             ctl;
		logic [VALUE_BITS-1:0] nxt;

		assign valid[g]      = (CNT_BITS'(g) < held_q);
		assign ctl.cmp_en    = in_xfer;
		assign ctl.append_en = do_append && (held_q == CNT_BITS'(g));
		assign ctl.shift_en  = do_remove && prefix[g];

		if (g == DEPTH - 1) begin : g_last
			assign nxt = entry[g];
		end else begin : g_mid
			assign nxt = entry[g+1];
		end

		cvl_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.valid      (valid[g]),
			.value      (bus_value),
			.next_entry (nxt),
			.entry      (entry[g]),
			.match      (match[g])
		);
	end

	always_comb begin
		logic acc;
		acc     = 1'b0;
		hit     = 1'b0;
		hit_pos = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit     = 1'b1;
				hit_pos = IDX_BITS'(i);
			end
		end
		for (int i = 0; i < DEPTH; i++) begin
			acc       = acc | match[i];
			prefix[i] = acc;
		end
	end

	always_comb begin
		res_status = ST_DONE;
		res_pos    = '0;
		res_value  = '0;
		res_held   = held_q;
		do_append  = 1'b0;
		do_remove  = 1'b0;
		unique case (act_q)
			ACT_FIND: begin
				if (hit) begin
					res_pos = hit_pos;
				end else begin
					res_status = ST_MISS;
				end
			end
			ACT_APPEND: begin
				if (full) begin
					res_status = ST_FULL;
				end else begin
					do_append = fire;
					res_held  = held_q + CNT_BITS'(1);
				end
			end
			ACT_REMOVE: begin
				if (hit) begin
					res_pos   = hit_pos;
					do_remove = fire;
					res_held  = held_q - CNT_BITS'(1);
				end else begin
					res_status = ST_MISS;
				end
			end
			ACT_READ: begin
				if (valid[pos_q]) begin
					res_value = entry[pos_q];
				end else begin
					res_status = ST_MISS;
				end
			end
			ACT_CLEAR: begin
				res_held = '0;
			end
			default: begin
				res_status = ST_MISS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			held_q   <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			act_q    <= '0;
			value_q  <= '0;
			pos_q    <= '0;
		end else begin
			if (fire) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_xfer) begin
						act_q   <= s_tdata[2:0];
						value_q <= s_tdata[26:3];
						pos_q   <= s_tdata[32:27];
						state_q <= EXEC;
					end
				end
				EXEC: begin
					if (fire) begin
						held_q   <= res_held;
						m_tdata  <= {1'b0, res_held, res_value, res_pos, res_status};
						state_q  <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_BITS'(DEPTH))
		else $error("count beyond capacity");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == EXEC))
		else $error("input transfer did not start execution");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[1:0] == ST_FULL)) |-> (m_tdata[38:32] == CNT_BITS'(DEPTH)))
		else $error("full reported below capacity");

	a_fire_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (m_tvalid && (state_q == IDLE)))
		else $error("result not registered after execution");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import cvl_pkg::*;

	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
	localparam int         RANDOM_ITEMS    = 1700;
	localparam int         POOL_SIZE       = 8;

	typedef struct packed {
		logic [6:0]            pad;
		logic [IDX_BITS-1:0]   position;
		logic [VALUE_BITS-1:0] value;
		logic [2:0]            action;
	} request_t;

	typedef struct packed {
		logic                  pad;
		logic [CNT_BITS-1:0]   count;
		logic [VALUE_BITS-1:0] value;
		logic [IDX_BITS-1:0]   position;
		logic [1:0]            status;
	} reply_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	request_t pending[$];
	reply_t   replies[$];

	logic [VALUE_BITS-1:0] list_vals[DEPTH];
	int                    list_held;

	int       burst_left;
	int       gap_left;
	int       rx_cycle;
	int       rx_hold;
	int       rx_mode;
	int       errors;
	reply_t   got;
	reply_t   want;

	compacting_value_list_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int lowest_match(logic [VALUE_BITS-1:0] v);
		for (int i = 0; i < list_held; i++) begin
			if (list_vals[i] == v)
				return i;
		end
		return -1;
	endfunction

	function automatic reply_t serve_request(request_t r);
		reply_t y;
		int     hit;
		y = '0;
		y.status = ST_DONE;
		case (r.action)
			ACT_FIND: begin
				hit = lowest_match(r.value);
				if (hit >= 0)
					y.position = IDX_BITS'(hit);
				else
					y.status = ST_MISS;
			end
			ACT_APPEND: begin
				if (list_held >= DEPTH) begin
					y.status = ST_FULL;
				end else begin
					list_vals[list_held] = r.value;
					list_held++;
				end
			end
			ACT_REMOVE: begin
				hit = lowest_match(r.value);
				if (hit >= 0) begin
					y.position = IDX_BITS'(hit);
					for (int i = hit; i < list_held - 1; i++)
						list_vals[i] = list_vals[i + 1];
					list_held--;
				end else begin
					y.status = ST_MISS;
				end
			end
			ACT_READ: begin
				if (int'(r.position) < list_held)
					y.value = list_vals[r.position];
				else
					y.status = ST_MISS;
			end
			ACT_CLEAR: begin
				list_held = 0;
			end
			default: begin
				y.status = ST_MISS;
			end
		endcase
		y.count = CNT_BITS'(list_held);
		return y;
	endfunction

	task automatic queue_request(logic [2:0] act, logic [VALUE_BITS-1:0] v,
			logic [IDX_BITS-1:0] pos);
		request_t r;
		r = '0;
		r.action = act;
		r.value = v;
		r.position = pos;
		pending = {pending, r};
	endtask

	// sender: bursts and gaps, hold while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			burst_left = 0;
			gap_left = 0;
			list_held = 0;
		end else begin
			if (s_tvalid && s_tready)
				replies = {replies, serve_request(pending.pop_front())};
			if (!(s_tvalid && !s_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (pending.size() > 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= pending[0];
					if (burst_left == 0)
						burst_left = $urandom_range(1, 30);
					burst_left--;
					if (burst_left == 0)
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern by mode, with long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_cycle = 0;
			rx_hold = 0;
			rx_mode = 0;
		end else begin
			rx_cycle++;
			if (rx_cycle % 4000 == 1500)
				rx_hold = 300;
			if (rx_cycle % 64 == 0)
				rx_mode = $urandom_range(0, 2);
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (replies.size() == 0) begin
				errors++;
				$display("%0t: unexpected result status=%0d position=%0d value=%h count=%0d",
					$time, got.status, got.position, got.value, got.count);
			end else begin
				want = replies.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: expected status=%0d position=%0d value=%h count=%0d pad=%b",
						$time, want.status, want.position, want.value, want.count, want.pad);
					$display("%0t: actual   status=%0d position=%0d value=%h count=%0d pad=%b",
						$time, got.status, got.position, got.value, got.count, got.pad);
				end
			end
		end
	end

	initial begin
		logic [VALUE_BITS-1:0] pool[POOL_SIZE];
		logic [VALUE_BITS-1:0] v;
		logic [2:0]            act;
		int                    made;
		int                    phase_len;
		int                    phase_kind;
		int                    pick;

		errors = 0;

		queue_request(ACT_CLEAR, '0, '0);
		queue_request(ACT_FIND, '0, '0);
		queue_request(ACT_REMOVE, '1, '1);
		queue_request(ACT_READ, '0, '0);
		queue_request(ACT_APPEND, '0, '1);
		queue_request(ACT_APPEND, '1, '0);
		queue_request(ACT_APPEND, '0, '0);
		queue_request(ACT_FIND, '0, '1);
		queue_request(ACT_FIND, '1, '0);
		queue_request(ACT_READ, '1, IDX_BITS'(1));
		queue_request(ACT_READ, '0, IDX_BITS'(2));
		queue_request(ACT_READ, '0, IDX_BITS'(3));
		queue_request(ACT_READ, '0, '1);
		queue_request(ACT_REMOVE, '0, '0);
		queue_request(ACT_READ, '0, IDX_BITS'(0));
		queue_request(ACT_READ, '0, IDX_BITS'(1));
		queue_request(ACT_FIND, 24'h5A5A5A, '0);
		queue_request(ACT_SPARE_FIRST, '1, '1);
		queue_request(ACT_SPARE_FIRST + 3'd1, '0, '0);
		queue_request(ACT_SPARE_LAST, '1, '1);
		queue_request(ACT_CLEAR, '1, '1);
		queue_request(ACT_READ, '0, IDX_BITS'(0));
		queue_request(ACT_REMOVE, '0, '0);

		// fill past capacity, then probe the top entry
		for (int i = 0; i < DEPTH + 4; i++)
			queue_request(ACT_APPEND, VALUE_BITS'($urandom()), IDX_BITS'($urandom()));
		queue_request(ACT_READ, '0, '1);
		queue_request(ACT_FIND, pending[pending.size() - 6].value, '0);
		queue_request(ACT_CLEAR, '0, '0);
		made = DEPTH + 7;

		while (made < RANDOM_ITEMS) begin
			for (int i = 0; i < POOL_SIZE; i++) begin
				case ($urandom_range(0, 9))
					0: pool[i] = '0;
					1: pool[i] = '1;
					default: pool[i] = VALUE_BITS'($urandom());
				endcase
			end
			phase_kind = $urandom_range(0, 2);
			phase_len = $urandom_range(40, 120);
			for (int n = 0; n < phase_len; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 2)
					act = ACT_CLEAR;
				else if (pick < 3)
					act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
				else begin
					pick = $urandom_range(0, 99);
					case (phase_kind)
						0: act = (pick < 70) ? ACT_APPEND : (pick < 80) ? ACT_FIND :
							(pick < 92) ? ACT_READ : ACT_REMOVE;
						1: act = (pick < 15) ? ACT_APPEND : (pick < 30) ? ACT_FIND :
							(pick < 45) ? ACT_READ : ACT_REMOVE;
						default: act = (pick < 35) ? ACT_APPEND : (pick < 55) ? ACT_FIND :
							(pick < 75) ? ACT_READ : ACT_REMOVE;
					endcase
				end
				if ($urandom_range(0, 99) < 85)
					v = pool[$urandom_range(0, POOL_SIZE - 1)];
				else
					v = VALUE_BITS'($urandom());
				queue_request(act, v, IDX_BITS'($urandom()));
				made++;
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || replies.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (errors == 0)
			$display("compacting_value_list_core: match");
		else
			$display("compacting_value_list_core: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("compacting_value_list_core: mismatch");
		$finish;
	end

endmodule

// File: sim.f
rtl/cvl_pkg.sv
rtl/cvl_cell.sv
rtl/compacting_value_list_core.sv
test/tb_top.sv
